/* rtl/hgcd_pkg.sv */
// ----------------------------------------------------------------------------
// hgcd_pkg
// Shared types, codes and neighbor tables of the hex grid distance fill.
// ----------------------------------------------------------------------------
package hgcd_pkg;

	localparam int DEF_MAX_COLS = 32;
	localparam int DEF_MAX_ROWS = 32;

	localparam logic [6:0] FAR_DIST = 7'd99;
	localparam logic [6:0] ZERO_DIST = 7'd0;

	// op codes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_COMPUTE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	// config register indexes
	localparam logic [1:0] REG_MAP_WIDTH = 2'd0;
	localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TARGET_COL = 2'd2;
	localparam logic [1:0] REG_TARGET_ROW = 2'd3;

	// relaxation step numbers
	localparam logic [2:0] STEP_FIRST = 3'd0;
	localparam logic [2:0] STEP_OWN = 3'd6;
	localparam logic [2:0] STEP_UPDATE = 3'd7;

	typedef struct packed {
		logic [1:0] op;
		logic [4:0] col;
		logic [4:0] row;
		logic [6:0] cell_cost;
		logic       passable;
	} in_item_t;

	typedef struct packed {
		logic [6:0] distance;
		logic [1:0] done_op;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_RELAX,
		ST_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic accept;
		logic clear;
		logic seed;
		logic relax;
		logic rearm;
	} hgcd_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic tgt_in;
		logic pass_end;
		logic changed;
	} hgcd_stat_t;

	// column offset of neighbor k, by row parity
	function automatic logic signed [1:0] nb_dcol(input logic odd, input logic [2:0] k);
		logic signed [1:0] d;
		d = 2'sd0;
		if (!odd) begin
			unique case (k)
				3'd0: d = 2'sd0;
				3'd1: d = 2'sd1;
				3'd2: d = 2'sd0;
				3'd3: d = -2'sd1;
				3'd4: d = -2'sd1;
				3'd5: d = -2'sd1;
				default: d = 2'sd0;
			endcase
		end else begin
			unique case (k)
				3'd0: d = 2'sd1;
				3'd1: d = 2'sd1;
				3'd2: d = 2'sd1;
				3'd3: d = 2'sd0;
				3'd4: d = -2'sd1;
				3'd5: d = 2'sd0;
				default: d = 2'sd0;
			endcase
		end
		return d;
	endfunction

	// row offset of neighbor k, by row parity
	function automatic logic signed [1:0] nb_drow(input logic odd, input logic [2:0] k);
		logic signed [1:0] d;
		d = 2'sd0;
		if (!odd) begin
			unique case (k)
				3'd0: d = -2'sd1;
				3'd1: d = 2'sd0;
				3'd2: d = 2'sd1;
				3'd3: d = 2'sd1;
				3'd4: d = 2'sd0;
				3'd5: d = -2'sd1;
				default: d = 2'sd0;
			endcase
		end else begin
			unique case (k)
				3'd0: d = -2'sd1;
				3'd1: d = 2'sd0;
				3'd2: d = 2'sd1;
				3'd3: d = 2'sd1;
				3'd4: d = 2'sd0;
				3'd5: d = -2'sd1;
				default: d = 2'sd0;
			endcase
		end
		return d;
	endfunction

endpackage

/* rtl/hgcd_ctrl.sv */
// ----------------------------------------------------------------------------
// hgcd_ctrl
// Controller: input/output handshake and the clear, seed and relax sequence.
// ----------------------------------------------------------------------------
module hgcd_ctrl
	import hgcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_op,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  hgcd_stat_t stat,
	output hgcd_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;
	logic out_valid_q;
	logic in_acc;

	// input side is held while busy or while a result waits
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && in_op == OP_COMPUTE) state_d = ST_CLEAR;
			end
			ST_CLEAR: begin
				if (stat.clear_last) state_d = ST_SEED;
			end
			ST_SEED: begin
				state_d = stat.tgt_in ? ST_RELAX : ST_FINISH;
			end
			ST_RELAX: begin
				if (stat.pass_end && !stat.changed) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd = '0;
		cmd.accept = in_acc;
		unique case (state_q)
			ST_CLEAR: cmd.clear = 1'b1;
			ST_SEED: cmd.seed = 1'b1;
			ST_RELAX: begin
				cmd.relax = 1'b1;
				cmd.rearm = stat.pass_end && stat.changed;
			end
			default: cmd = cmd;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((in_acc && in_op != OP_COMPUTE) || state_q == ST_FINISH) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_acc_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> state_q == ST_IDLE) else $error("item accepted while busy");
	a_no_result_in_relax: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RELAX |-> !out_valid_q) else $error("result shown during relax");
	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH |=> out_valid_q) else $error("compute gave no result");
`endif

endmodule

/* rtl/hgcd_datapath.sv */
// ----------------------------------------------------------------------------
// hgcd_datapath
// Terrain and distance memories, config registers, cell sequencing and
// the relaxation arithmetic.
// ----------------------------------------------------------------------------
module hgcd_datapath
	import hgcd_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   in_data,
	output out_item_t  out_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data,
	input  hgcd_cmd_t  cmd,
	output hgcd_stat_t stat
);

	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [6:0] dist_mem [CELLS];
	logic [6:0] cost_mem [CELLS];
	logic       pass_mem [CELLS];

	logic [5:0] map_width_q, map_height_q;
	logic [4:0] target_col_q, target_row_q;
	logic [AW-1:0] clr_cnt_q;
	logic [CW-1:0] ccol_q;
	logic [RW-1:0] crow_q;
	logic [2:0] step_q;
	logic [6:0] best_q;
	logic changed_q;
	logic filled_q;
	logic ok_s1;
	logic [6:0] dist_rd_q;
	logic [6:0] cost_rd_q;
	logic pass_rd_q;
	logic [1:0] out_op_q;
	logic out_oob_q;

	int w_eff, h_eff, nc, nr;
	logic in_inside, slot_ok, tgt_in;
	logic [AW-1:0] in_addr, own_addr, nb_addr, tgt_addr;
	logic dm_we, dm_re, tm_we, tm_re;
	logic [AW-1:0] dm_waddr, dm_raddr;
	logic [6:0] dm_wdata;
	logic [7:0] cand;
	logic relax_we, cell_last;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= 6'd32;
			map_height_q <= 6'd32;
			target_col_q <= 5'd0;
			target_row_q <= 5'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAP_WIDTH: map_width_q <= cfg_data;
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				REG_TARGET_COL: target_col_q <= cfg_data[4:0];
				REG_TARGET_ROW: target_row_q <= cfg_data[4:0];
				default: map_width_q <= map_width_q;
			endcase
		end
	end

	// effective map size, addresses and neighbor bounds
	always_comb begin
		w_eff = (int'(map_width_q) > MAX_COLS) ? MAX_COLS : int'(map_width_q);
		h_eff = (int'(map_height_q) > MAX_ROWS) ? MAX_ROWS : int'(map_height_q);
		in_inside = (int'(in_data.col) < MAX_COLS) && (int'(in_data.row) < MAX_ROWS);
		in_addr = AW'(int'(in_data.row) * MAX_COLS + int'(in_data.col));
		tgt_in = (int'(target_col_q) < w_eff) && (int'(target_row_q) < h_eff);
		tgt_addr = AW'(int'(target_row_q) * MAX_COLS + int'(target_col_q));
		own_addr = AW'(int'(crow_q) * MAX_COLS + int'(ccol_q));
		nc = int'(ccol_q) + int'(nb_dcol(crow_q[0], step_q));
		nr = int'(crow_q) + int'(nb_drow(crow_q[0], step_q));
		if (step_q == STEP_OWN) begin
			slot_ok = 1'b1;
			nb_addr = own_addr;
		end else begin
			slot_ok = (nc >= 0) && (nc < w_eff) && (nr >= 0) && (nr < h_eff);
			nb_addr = AW'(nr * MAX_COLS + nc);
		end
		cell_last = (int'(ccol_q) == w_eff - 1) && (int'(crow_q) == h_eff - 1);
	end

	// candidate through the cheapest neighbor
	assign cand = {1'b0, best_q} + {1'b0, cost_rd_q};
	assign relax_we = cmd.relax && step_q == STEP_UPDATE && pass_rd_q &&
		cand < {1'b0, FAR_DIST} && cand < {1'b0, dist_rd_q};

	// memory port selection
	always_comb begin
		dm_we = 1'b0;
		dm_waddr = clr_cnt_q;
		dm_wdata = FAR_DIST;
		if (cmd.clear) begin
			dm_we = 1'b1;
		end else if (cmd.seed) begin
			dm_we = tgt_in;
			dm_waddr = tgt_addr;
			dm_wdata = ZERO_DIST;
		end else if (relax_we) begin
			dm_we = 1'b1;
			dm_waddr = own_addr;
			dm_wdata = cand[6:0];
		end
		dm_re = (cmd.accept && in_data.op == OP_READ && in_inside) ||
			(cmd.relax && step_q <= STEP_OWN);
		dm_raddr = cmd.relax ? nb_addr : in_addr;
		tm_we = cmd.accept && in_data.op == OP_LOAD && in_inside;
		tm_re = cmd.relax && step_q == STEP_FIRST;
	end

	// distance memory
	always_ff @(posedge clk) begin
		if (dm_we) dist_mem[dm_waddr] <= dm_wdata;
		if (dm_re) dist_rd_q <= dist_mem[dm_raddr];
	end

	// terrain memory
	always_ff @(posedge clk) begin
		if (tm_we) begin
			cost_mem[in_addr] <= in_data.cell_cost;
			pass_mem[in_addr] <= in_data.passable;
		end
		if (tm_re) begin
			cost_rd_q <= cost_mem[own_addr];
			pass_rd_q <= pass_mem[own_addr];
		end
	end

	// sequencing of clear sweep and relax passes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			ccol_q <= '0;
			crow_q <= '0;
			step_q <= STEP_FIRST;
			changed_q <= 1'b0;
			filled_q <= 1'b0;
		end else begin
			if (cmd.clear) begin
				clr_cnt_q <= (int'(clr_cnt_q) == CELLS - 1) ? '0 : clr_cnt_q + 1'b1;
				if (int'(clr_cnt_q) == CELLS - 1) filled_q <= 1'b1;
			end
			if (cmd.seed || cmd.rearm) begin
				ccol_q <= '0;
				crow_q <= '0;
				step_q <= STEP_FIRST;
				changed_q <= 1'b0;
			end else if (cmd.relax) begin
				step_q <= step_q + 3'd1;
				if (relax_we) changed_q <= 1'b1;
				if (step_q == STEP_UPDATE) begin
					if (int'(ccol_q) >= w_eff - 1) begin
						ccol_q <= '0;
						crow_q <= crow_q + 1'b1;
					end else begin
						ccol_q <= ccol_q + 1'b1;
					end
				end
			end
		end
	end

	// neighbor minimum over the six slots
	always_ff @(posedge clk) begin
		if (cmd.relax) begin
			ok_s1 <= slot_ok;
			if (step_q == STEP_FIRST) begin
				best_q <= FAR_DIST;
			end else if (step_q <= STEP_OWN && ok_s1 && dist_rd_q < best_q) begin
				best_q <= dist_rd_q;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_op_q <= in_data.op;
			out_oob_q <= !in_inside;
		end
	end

	always_comb begin
		out_data.done_op = out_op_q;
		if (out_op_q == OP_READ) begin
			out_data.distance = (out_oob_q || !filled_q) ? FAR_DIST : dist_rd_q;
		end else begin
			out_data.distance = ZERO_DIST;
		end
	end

	assign stat.clear_last = int'(clr_cnt_q) == CELLS - 1;
	assign stat.tgt_in = tgt_in;
	assign stat.pass_end = cmd.relax && step_q == STEP_UPDATE && cell_last;
	assign stat.changed = changed_q || relax_we;

endmodule

/* rtl/hex_grid_cost_distance_fill.sv */
// ----------------------------------------------------------------------------
// hex_grid_cost_distance_fill
// Distance fill over an offset-row hexagonal grid with per-cell entry costs.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_stall/in_data) takes one item per beat: load a
//   cell's terrain, run a distance fill, or read a cell's distance.
//   out channel (out_valid/out_stall/out_data) returns one beat per item,
//   in order. cfg channel (cfg_valid/cfg_ready) writes map size and target;
//   cfg_ready is always high, write only while the block is idle.
// Timing and throughput:
//   load and read: result in the cycle after acceptance, one item per cycle
//   while the output is not stalled. compute: clears the distance memory,
//   seeds the target, then runs relaxation passes over the map cells (per
//   cell six neighbor reads, one own read and one update on the single
//   distance read port) until a pass changes nothing, none if the target is
//   off the map; a finish state ends it and the input is stalled throughout.
// Reset: config returns to a 32 by 32 map with target (0,0); distances read
//   as 99 until the first compute. Terrain is undefined until loaded.
// Stall: a waiting result holds its beat and the input is stalled with it.
// ----------------------------------------------------------------------------
module hex_grid_cost_distance_fill
	import hgcd_pkg::*;
#(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [5:0] cfg_data
);

	hgcd_cmd_t cmd;
	hgcd_stat_t stat;

	assign cfg_ready = 1'b1;

	// controller
	hgcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_data.op),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	hgcd_datapath #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* tb/tb_hex_grid_cost_distance_fill.sv */
// ----------------------------------------------------------------------------
// tb_hex_grid_cost_distance_fill
// Self-checking bench: terrain loads, distance fills and reads are driven
// through the stall handshake, each beat is predicted by a behavioral fill
// model and compared field by field against the result stream, under
// several map sizes, targets and idle patterns on both channels.
// ----------------------------------------------------------------------------
module tb_hex_grid_cost_distance_fill;
	import hgcd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int NCOLS = DEF_MAX_COLS;
	localparam int NROWS = DEF_MAX_ROWS;
	localparam int LOAD_ROWS = 6;
	localparam int CYCLE_LIMIT = 6000000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [5:0] cfg_data = '0;

	// terrain and distance shadow of the block
	logic [6:0] cost_mem [NCOLS*NROWS];
	logic       pass_mem [NCOLS*NROWS];
	logic [6:0] dist_mem [NCOLS*NROWS];
	int unsigned map_w = 32, map_h = 32, tgt_col = 0, tgt_row = 0;

	in_item_t  pending_items[$];
	out_item_t expected_results[$];
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        errors = 0;
	int        cycles = 0;
	logic      beat_taken = 1'b0;

	hex_grid_cost_distance_fill i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// shortest path fill, saturated at far distance
	function automatic void relax_distances();
		int even_dc[6] = '{0, 1, 0, -1, -1, -1};
		int even_dr[6] = '{-1, 0, 1, 1, 0, -1};
		int odd_dc[6] = '{1, 1, 1, 0, -1, 0};
		int odd_dr[6] = '{-1, 0, 1, 1, 0, -1};
		int w, h, nc, nr, idx, nd, d;
		bit changed;
		w = (map_w > NCOLS) ? NCOLS : map_w;
		h = (map_h > NROWS) ? NROWS : map_h;
		foreach (dist_mem[i]) dist_mem[i] = FAR_DIST;
		if (tgt_col >= w || tgt_row >= h) return;
		dist_mem[tgt_row*NCOLS + tgt_col] = ZERO_DIST;
		do begin
			changed = 0;
			for (int r = 0; r < h; r++) begin
				for (int c = 0; c < w; c++) begin
					d = dist_mem[r*NCOLS + c];
					if (d >= FAR_DIST) continue;
					for (int k = 0; k < 6; k++) begin
						nc = c + ((r % 2 == 0) ? even_dc[k] : odd_dc[k]);
						nr = r + ((r % 2 == 0) ? even_dr[k] : odd_dr[k]);
						if (nc < 0 || nr < 0 || nc >= w || nr >= h) continue;
						idx = nr*NCOLS + nc;
						if (!pass_mem[idx]) continue;
						nd = d + cost_mem[idx];
						if (nd < FAR_DIST && nd < dist_mem[idx]) begin
							dist_mem[idx] = nd[6:0];
							changed = 1;
						end
					end
				end
			end
		end while (changed);
	endfunction

	// expected result of one accepted beat
	function automatic out_item_t predict_result(in_item_t it);
		out_item_t res;
		int idx;
		idx = it.row*NCOLS + it.col;
		res.distance = ZERO_DIST;
		res.done_op = it.op;
		case (it.op)
			OP_LOAD: begin
				cost_mem[idx] = it.cell_cost;
				pass_mem[idx] = it.passable;
			end
			OP_COMPUTE: relax_distances();
			OP_READ: res.distance = dist_mem[idx];
			default: ;
		endcase
		return res;
	endfunction

	function automatic in_item_t make_item(logic [1:0] op, int c, int r, int cost, bit p);
		in_item_t it;
		it.op = op;
		it.col = c[4:0];
		it.row = r[4:0];
		it.cell_cost = cost[6:0];
		it.passable = p;
		return it;
	endfunction

	// append one beat to the driver queue
	function automatic void enqueue(in_item_t it);
		pending_items = {pending_items, it};
	endfunction

	// driver: new beat only when the previous one was taken
	always @(negedge clk) begin
		if (arst_n && (!in_valid || beat_taken)) begin
			if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= arst_n && ($urandom_range(0, 99) < recv_idle_pct);
	end

	// monitor: check results, predict accepted beats
	always @(posedge clk) begin
		out_item_t want;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("Simulation FAILED");
			$finish;
		end
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t unexpected beat: got dist=%0d op=%0d", $time,
					out_data.distance, out_data.done_op);
				errors++;
			end else begin
				want = expected_results.pop_front();
				if (want.distance !== out_data.distance)
					begin
					$display("%0t distance: expected %0d actual %0d", $time,
						want.distance, out_data.distance);
					errors++;
				end
				if (want.done_op !== out_data.done_op) begin
					$display("%0t done_op: expected %0d actual %0d", $time,
						want.done_op, out_data.done_op);
					errors++;
				end
			end
		end
		beat_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall)
			expected_results = {expected_results, predict_result(in_data)};
	end

	task automatic write_reg(logic [1:0] idx, int val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[5:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MAP_WIDTH: map_w = val & 6'h3f;
			REG_MAP_HEIGHT: map_h = val & 6'h3f;
			REG_TARGET_COL: tgt_col = val & 5'h1f;
			default: tgt_row = val & 5'h1f;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_map(int w, int h, int tc, int tr);
		write_reg(REG_MAP_WIDTH, w);
		write_reg(REG_MAP_HEIGHT, h);
		write_reg(REG_TARGET_COL, tc);
		write_reg(REG_TARGET_ROW, tr);
	endtask

	// wait until the block is idle with nothing outstanding
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0);
		repeat (20) @(posedge clk);
	endtask

	// random beats over a small map, mostly loads and reads inside it
	task automatic random_phase(int n);
		int w, h, sel;
		w = $urandom_range(1, 6);
		h = $urandom_range(1, 6);
		set_map(w, h, $urandom_range(0, 7), $urandom_range(0, 7));
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45)
				enqueue(make_item(OP_LOAD, $urandom_range(0, w),
					$urandom_range(0, h), $urandom_range(0, 20), $urandom_range(0, 5) != 0));
			else if (sel < 55)
				enqueue(make_item(OP_LOAD, $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom_range(0, 127), $urandom_range(0, 1)));
			else if (sel < 80)
				enqueue(make_item(OP_READ, $urandom_range(0, w),
					$urandom_range(0, h), $urandom, $urandom));
			else if (sel < 88)
				enqueue(make_item(OP_READ, $urandom_range(0, 31),
					$urandom_range(0, 31), $urandom, $urandom));
			else if (sel < 96)
				enqueue(make_item(OP_COMPUTE, $urandom, $urandom,
					$urandom, $urandom));
			else
				enqueue(make_item(OP_UNUSED, $urandom, $urandom,
					$urandom, $urandom));
		end
		// finish with a fill and a sweep of reads over the map
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		for (int r = 0; r < h; r++)
			for (int c = 0; c < w; c++)
				enqueue(make_item(OP_READ, c, r, $urandom, $urandom));
		drain();
	endtask

	initial begin
		foreach (dist_mem[i]) dist_mem[i] = FAR_DIST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// full width map over the loaded rows
		set_map(NCOLS, LOAD_ROWS, 7, 3);

		// every row a fill may touch is loaded so no fill sees unwritten terrain
		for (int r = 0; r < LOAD_ROWS; r++)
			for (int c = 0; c < NCOLS; c++)
				enqueue(make_item(OP_LOAD, c, r,
					$urandom_range(1, 40), $urandom_range(0, 3) != 0));
		// cost extremes at a far corner, read before any fill
		enqueue(make_item(OP_LOAD, 31, 31, 127, 1'b1));
		enqueue(make_item(OP_LOAD, 30, 31, 0, 1'b1));
		enqueue(make_item(OP_READ, 31, 31, 0, 0));
		enqueue(make_item(OP_UNUSED, 31, 31, 127, 1'b1));
		// full width fill, corners of the map and a cell outside it
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 31, 0, 0, 0));
		enqueue(make_item(OP_READ, 0, 5, 0, 0));
		enqueue(make_item(OP_READ, 31, 5, 0, 0));
		enqueue(make_item(OP_READ, 31, 31, 0, 0));
		drain();

		// oversized width clamps, impassable target still spreads
		set_map(63, 2, 31, 1);
		enqueue(make_item(OP_LOAD, 31, 1, 5, 1'b0));
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 31, 1, 0, 0));
		enqueue(make_item(OP_READ, 30, 1, 0, 0));
		enqueue(make_item(OP_READ, 31, 0, 0, 0));
		drain();

		// target outside the map, then an empty map and a one-cell map
		set_map(4, 32, 5, 31);
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 3, 31, 0, 0));
		drain();
		set_map(0, 0, 0, 0);
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 0, 0, 0, 0));
		drain();
		set_map(1, 1, 0, 0);
		enqueue(make_item(OP_COMPUTE, 0, 0, 0, 0));
		enqueue(make_item(OP_READ, 0, 0, 0, 0));
		drain();

		// random part under three idle patterns
		send_idle_pct = 19; recv_idle_pct = 85;
		repeat (4) random_phase(12);
		send_idle_pct = 85; recv_idle_pct = 19;
		repeat (4) random_phase(12);
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (4) random_phase(12);

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
